// ===== design/lsc_pkg.sv =====
// Shared types and constants for the link statistics counters.
`timescale 1ns / 1ps

package lsc_pkg;

  // Default widths of the counters and latency sums
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned SUM_WIDTH_DEF   = 48;

  // Fixed field widths
  localparam int unsigned CMD_W  = 5;
  localparam int unsigned LAT_W  = 16;
  localparam int unsigned SEL_W  = 5;
  localparam int unsigned STAT_W = 48;

  localparam logic [LAT_W-1:0] LAT_MAX = 16'hFFFF;

  // Event counter store
  localparam int unsigned NUM_COUNTERS = 15;
  localparam int unsigned CNT_AW       = $clog2(NUM_COUNTERS);
  localparam logic [CNT_AW-1:0] CNT_IDX_RCVD  = 4'd1;
  localparam logic [CNT_AW-1:0] CNT_IDX_TOTAL = 4'd14;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SENT      = 5'd1;
  localparam logic [CMD_W-1:0] CMD_ACK_RCVD  = 5'd4;
  localparam logic [CMD_W-1:0] CMD_ERR_FIRST = 5'd5;
  localparam logic [CMD_W-1:0] CMD_ERR_LAST  = 5'd14;
  localparam logic [CMD_W-1:0] CMD_TX_LAT    = 5'd15;
  localparam logic [CMD_W-1:0] CMD_RX_LAT    = 5'd16;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 5'd17;

  // Statistic index map
  localparam logic [SEL_W-1:0] STAT_TX_BASE = 5'd15;
  localparam logic [SEL_W-1:0] STAT_RX_BASE = 5'd20;
  localparam logic [SEL_W-1:0] STAT_END     = 5'd25;

  // Field within one direction's latency record
  localparam logic [2:0] FLD_COUNT = 3'd0;
  localparam logic [2:0] FLD_MAX   = 3'd1;
  localparam logic [2:0] FLD_MIN   = 3'd2;
  localparam logic [2:0] FLD_SUM   = 3'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_LAT_RD,
    ST_LAT_UPD,
    ST_DIV,
    ST_LAT_WR,
    ST_SEL_RD,
    ST_RESP
  } lsc_state_e;

endpackage

// ===== design/lsc_if.sv =====
// Item channels: event input and statistic result.
`timescale 1ns / 1ps

interface lsc_in_if
  import lsc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [LAT_W-1:0] latency_value;
  logic [SEL_W-1:0] stat_index;

  modport source (output valid, command, latency_value, stat_index, input ready);
  modport sink   (input valid, command, latency_value, stat_index, output ready);
endinterface

interface lsc_out_if
  import lsc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] stat_value;

  modport source (output valid, stat_value, input ready);
  modport sink   (input valid, stat_value, output ready);
endinterface

// ===== design/link_statistics_counters_unit.sv =====
// Top level of the link statistics counters.
`timescale 1ns / 1ps

// Takes one event item at a time and returns the selected statistic after the
// update. The fifteen event counters sit in a small synchronous memory and the
// two latency records (count, max, min, sum, average for tx and rx) in a second
// two-entry memory; each update is a read, modify and write back. Per-entry
// valid bits give reset and clear without a clearing pass. Events that change
// nothing or clear go straight to reading the result; a single counter event
// does one counter update, ack received and error events two; a non-zero
// latency sample also runs the bit-serial divider that forms the average,
// unless the sample count wraps to zero and the divide is skipped. The input is
// ready again once the result is loaded into the output register.

module link_statistics_counters_unit
  import lsc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned SUM_WIDTH   = SUM_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsc_in_if.sink    in_i,
  lsc_out_if.source out_o
);

  localparam int unsigned OFF_MAX = COUNT_WIDTH;
  localparam int unsigned OFF_MIN = OFF_MAX + LAT_W;
  localparam int unsigned OFF_SUM = OFF_MIN + LAT_W;
  localparam int unsigned OFF_AVG = OFF_SUM + SUM_WIDTH;
  localparam int unsigned LREC_W  = OFF_AVG + LAT_W;

  lsc_state_e state_q, state_d;

  logic [LAT_W-1:0]  lat_q;
  logic [SEL_W-1:0]  sel_q;
  logic [CNT_AW-1:0] cur_addr_q, cur_addr_d;
  logic              pend_q, pend_d;
  logic [CNT_AW-1:0] pend_addr_q, pend_addr_d;
  logic              dir_q, dir_d;

  // Memories and their valid bits
  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_COUNTERS];
  logic [LREC_W-1:0]      lat_mem [2];
  logic [NUM_COUNTERS-1:0] cnt_vld_q;
  logic [1:0]             lat_vld_q;
  logic [COUNT_WIDTH-1:0] cnt_rdata_q;
  logic [LREC_W-1:0]      lat_rdata_q;
  logic                   cnt_rvld_q;
  logic                   lat_rvld_q;

  logic                   cnt_we;
  logic [CNT_AW-1:0]      cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_base;
  logic                   lat_we;
  logic                   lat_raddr;
  logic                   clear_all;

  // Latency record being updated
  logic [COUNT_WIDTH-1:0] rd_count, new_count, upd_count_q;
  logic [LAT_W-1:0]       rd_max, new_max, upd_max_q;
  logic [LAT_W-1:0]       rd_min, new_min, upd_min_q;
  logic [SUM_WIDTH-1:0]   rd_sum, new_sum, upd_sum_q;
  logic [LAT_W-1:0]       rd_avg, upd_avg_q;
  logic                   upd_ld;
  logic                   avg_ld;

  logic                   div_start;
  logic                   div_done;
  logic [LAT_W-1:0]       div_quot;

  logic                   out_valid_q;
  logic [STAT_W-1:0]      out_data_q;
  logic [STAT_W-1:0]      out_data_d;
  logic                   out_ld;
  logic                   in_acc;
  logic [SEL_W-1:0]       fld_full;
  logic [2:0]             fld;

  assign in_acc = in_i.valid && in_i.ready;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_addr_d  = cur_addr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    dir_d       = dir_q;
    cnt_raddr   = cur_addr_q;
    cnt_we      = 1'b0;
    lat_raddr   = dir_q;
    lat_we      = 1'b0;
    clear_all   = 1'b0;
    upd_ld      = 1'b0;
    avg_ld      = 1'b0;
    div_start   = 1'b0;
    out_ld      = 1'b0;
    in_i.ready  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.command >= CMD_SENT && in_i.command <= CMD_ERR_LAST) begin
            cur_addr_d  = CNT_AW'(in_i.command - CMD_SENT);
            pend_d      = (in_i.command >= CMD_ACK_RCVD);
            pend_addr_d = (in_i.command >= CMD_ERR_FIRST) ? CNT_IDX_TOTAL : CNT_IDX_RCVD;
            state_d     = ST_CNT_RD;
          end else if ((in_i.command == CMD_TX_LAT || in_i.command == CMD_RX_LAT) &&
                       in_i.latency_value != '0) begin
            dir_d   = (in_i.command == CMD_RX_LAT);
            state_d = ST_LAT_RD;
          end else begin
            clear_all = (in_i.command == CMD_CLEAR);
            state_d   = ST_SEL_RD;
          end
        end
      end
      ST_CNT_RD: begin
        state_d = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cnt_we = 1'b1;
        if (pend_q) begin
          cur_addr_d = pend_addr_q;
          pend_d     = 1'b0;
          state_d    = ST_CNT_RD;
        end else begin
          state_d = ST_SEL_RD;
        end
      end
      ST_LAT_RD: begin
        state_d = ST_LAT_UPD;
      end
      ST_LAT_UPD: begin
        upd_ld = 1'b1;
        if (new_count != '0) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_LAT_WR;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_ld  = 1'b1;
          state_d = ST_LAT_WR;
        end
      end
      ST_LAT_WR: begin
        lat_we  = 1'b1;
        state_d = ST_SEL_RD;
      end
      ST_SEL_RD: begin
        cnt_raddr = (sel_q < SEL_W'(NUM_COUNTERS)) ? sel_q[CNT_AW-1:0] : '0;
        lat_raddr = (sel_q >= STAT_RX_BASE);
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        // keep reading the selected entry while the output is stalled
        cnt_raddr = (sel_q < SEL_W'(NUM_COUNTERS)) ? sel_q[CNT_AW-1:0] : '0;
        lat_raddr = (sel_q >= STAT_RX_BASE);
        if (!out_valid_q || out_o.ready) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Item and address registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lat_q <= in_i.latency_value;
      sel_q <= in_i.stat_index;
    end
    cur_addr_q  <= cur_addr_d;
    pend_addr_q <= pend_addr_d;
    dir_q       <= dir_d;
  end

  // Counter increment
  assign cnt_base = cnt_rvld_q ? cnt_rdata_q : '0;

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cur_addr_q] <= cnt_base + COUNT_WIDTH'(1);
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lat_we) begin
      lat_mem[dir_q] <= {upd_avg_q, upd_sum_q, upd_min_q, upd_max_q, upd_count_q};
    end
    lat_rdata_q <= lat_mem[lat_raddr];
  end

  // Valid bits: an entry not written since reset or clear reads as its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q  <= '0;
      lat_vld_q  <= '0;
      cnt_rvld_q <= 1'b0;
      lat_rvld_q <= 1'b0;
    end else begin
      cnt_rvld_q <= cnt_vld_q[cnt_raddr];
      lat_rvld_q <= lat_vld_q[lat_raddr];
      if (clear_all) begin
        cnt_vld_q <= '0;
        lat_vld_q <= '0;
      end else begin
        if (cnt_we) begin
          cnt_vld_q[cur_addr_q] <= 1'b1;
        end
        if (lat_we) begin
          lat_vld_q[dir_q] <= 1'b1;
        end
      end
    end
  end

  // Unpack the latency record read from memory
  assign rd_count = lat_rvld_q ? lat_rdata_q[0 +: COUNT_WIDTH]     : '0;
  assign rd_max   = lat_rvld_q ? lat_rdata_q[OFF_MAX +: LAT_W]     : '0;
  assign rd_min   = lat_rvld_q ? lat_rdata_q[OFF_MIN +: LAT_W]     : LAT_MAX;
  assign rd_sum   = lat_rvld_q ? lat_rdata_q[OFF_SUM +: SUM_WIDTH] : '0;
  assign rd_avg   = lat_rvld_q ? lat_rdata_q[OFF_AVG +: LAT_W]     : '0;

  // New sample
  assign new_count = rd_count + COUNT_WIDTH'(1);
  assign new_max   = (lat_q > rd_max) ? lat_q : rd_max;
  assign new_min   = (lat_q < rd_min) ? lat_q : rd_min;
  assign new_sum   = rd_sum + SUM_WIDTH'(lat_q);

  always_ff @(posedge clk_i) begin
    if (upd_ld) begin
      upd_count_q <= new_count;
      upd_max_q   <= new_max;
      upd_min_q   <= new_min;
      upd_sum_q   <= new_sum;
      upd_avg_q   <= rd_avg;
    end else if (avg_ld) begin
      upd_avg_q <= div_quot;
    end
  end

  // Average = sum / count; a wrapped count of zero keeps the old average
  lsc_div #(
    .SUM_WIDTH   (SUM_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (new_sum),
    .divisor_i  (new_count),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Result selection
  assign fld_full = (sel_q >= STAT_RX_BASE) ? (sel_q - STAT_RX_BASE) : (sel_q - STAT_TX_BASE);
  assign fld      = fld_full[2:0];

  always_comb begin
    out_data_d = '0;
    if (sel_q < SEL_W'(NUM_COUNTERS)) begin
      out_data_d = STAT_W'(cnt_base);
    end else if (sel_q < STAT_END) begin
      case (fld)
        FLD_COUNT: out_data_d = STAT_W'(rd_count);
        FLD_MAX:   out_data_d = STAT_W'(rd_max);
        FLD_MIN:   out_data_d = STAT_W'(rd_min);
        FLD_SUM:   out_data_d = STAT_W'(rd_sum);
        default:   out_data_d = STAT_W'(rd_avg);
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.stat_value = out_data_q;

  // Checks
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input accepted while an item is in flight");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.command == CMD_CLEAR) |=> (cnt_vld_q == '0 && lat_vld_q == '0))
    else $error("clear left a valid entry");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RESP)
    else $error("result raised outside the response state");

endmodule

// ===== design/lsc_div.sv =====
// Bit-serial restoring divider for the latency average, saturated to 16 bits.
`timescale 1ns / 1ps

module lsc_div
  import lsc_pkg::*;
#(
  parameter int unsigned SUM_WIDTH   = SUM_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SUM_WIDTH-1:0]   dividend_i,
  input  logic [COUNT_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [LAT_W-1:0]       quot_o
);

  localparam int unsigned STEP_W = $clog2(SUM_WIDTH + 1);

  logic                   busy_q;
  logic                   done_q;
  logic [STEP_W-1:0]      step_q;
  logic [SUM_WIDTH-1:0]   quo_q;
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [COUNT_WIDTH-1:0] dvs_q;

  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH:0]   rem_sub;
  logic                   ge;

  // One quotient bit per cycle: shift in the next dividend bit, trial subtract
  assign rem_sh  = {rem_q, quo_q[SUM_WIDTH-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_WIDTH);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top as quotient bits enter the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_WIDTH-2:0], ge};
      rem_q <= ge ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = (|quo_q[SUM_WIDTH-1:LAT_W]) ? LAT_MAX : quo_q[LAT_W-1:0];

endmodule

// ===== verif/tb_link_statistics_counters_unit.sv =====
// Testbench for the link statistics counters: directed table, then random events checked by a predictor.
`timescale 1ns / 1ps

module tb_link_statistics_counters_unit;
  import lsc_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_NONE       = 5'd0;
  localparam logic [CMD_W-1:0] CMD_PKT_RCVD   = 5'd2;
  localparam logic [CMD_W-1:0] CMD_ACK_SENT   = 5'd3;
  localparam logic [CMD_W-1:0] CMD_UNUSED_TOP = 5'd31;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LOW = 5'd18;
  localparam logic [2:0]       FLD_AVG        = 3'd4;
  localparam logic [SEL_W-1:0] SEL_TOP        = 5'd31;

  localparam int DIR_TX = 0;
  localparam int DIR_RX = 1;

  localparam int RANDOM_ITEMS  = 2000;
  localparam int STEADY_FIRST  = 800;
  localparam int STEADY_LAST   = 1100;
  localparam int HOLD_AT_ITEM  = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PERCENT  = 34;
  localparam int DRAIN_CYCLES  = SUM_WIDTH_DEF + 16;

  logic clk_i;
  logic rst_ni;

  lsc_in_if  in_ch ();
  lsc_out_if out_ch ();

  link_statistics_counters_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // One row of the directed table
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [LAT_W-1:0]  lat;
    logic [SEL_W-1:0]  sel;
    bit                known;
    logic [STAT_W-1:0] value;
  } stim_row_t;

  // Latency record of one direction
  typedef struct packed {
    logic [COUNT_WIDTH_DEF-1:0] samples;
    logic [LAT_W-1:0]           peak;
    logic [LAT_W-1:0]           low;
    logic [SUM_WIDTH_DEF-1:0]   total;
    logic [LAT_W-1:0]           mean;
  } lat_track_t;

  logic [COUNT_WIDTH_DEF-1:0] evt_count [NUM_COUNTERS];
  lat_track_t                 lat_track [2];

  logic [STAT_W-1:0] expected_stats [$];
  stim_row_t         directed_rows [$];

  int  error_count     = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  latency_items   = 0;
  int  clear_items     = 0;
  bit  steady_flow     = 1'b0;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Timeout
  initial begin
    #16_000_000;
    $display("link_statistics_counters_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_stats();
    for (int i = 0; i < NUM_COUNTERS; i++) evt_count[i] = '0;
    for (int d = 0; d < 2; d++) begin
      lat_track[d].samples = '0;
      lat_track[d].peak    = '0;
      lat_track[d].low     = LAT_MAX;
      lat_track[d].total   = '0;
      lat_track[d].mean    = '0;
    end
  endfunction

  function automatic void take_sample(input int dir, input logic [LAT_W-1:0] v);
    logic [SUM_WIDTH_DEF-1:0] quo;
    if (v == '0) return;
    if (v > lat_track[dir].peak) lat_track[dir].peak = v;
    if (v < lat_track[dir].low)  lat_track[dir].low  = v;
    lat_track[dir].samples = lat_track[dir].samples + COUNT_WIDTH_DEF'(1);
    lat_track[dir].total   = lat_track[dir].total + SUM_WIDTH_DEF'(v);
    // count wrapped to zero: average held
    if (lat_track[dir].samples != '0) begin
      quo = lat_track[dir].total / SUM_WIDTH_DEF'(lat_track[dir].samples);
      lat_track[dir].mean = (quo > SUM_WIDTH_DEF'(LAT_MAX)) ? LAT_MAX : quo[LAT_W-1:0];
    end
  endfunction

  function automatic logic [STAT_W-1:0] read_track(input int dir, input logic [2:0] fld);
    case (fld)
      FLD_COUNT: return STAT_W'(lat_track[dir].samples);
      FLD_MAX:   return STAT_W'(lat_track[dir].peak);
      FLD_MIN:   return STAT_W'(lat_track[dir].low);
      FLD_SUM:   return STAT_W'(lat_track[dir].total);
      default:   return STAT_W'(lat_track[dir].mean);
    endcase
  endfunction

  // Apply one event and return the selected statistic afterwards
  function automatic logic [STAT_W-1:0] stat_after_event(input logic [CMD_W-1:0] c,
                                                         input logic [LAT_W-1:0] v,
                                                         input logic [SEL_W-1:0] s);
    logic [SEL_W-1:0] off;
    if (c >= CMD_SENT && c <= CMD_ERR_LAST) begin
      evt_count[c - CMD_SENT] = evt_count[c - CMD_SENT] + COUNT_WIDTH_DEF'(1);
      // ack received also counts as a received packet
      if (c == CMD_ACK_RCVD)
        evt_count[CNT_IDX_RCVD] = evt_count[CNT_IDX_RCVD] + COUNT_WIDTH_DEF'(1);
      if (c >= CMD_ERR_FIRST)
        evt_count[CNT_IDX_TOTAL] = evt_count[CNT_IDX_TOTAL] + COUNT_WIDTH_DEF'(1);
    end else if (c == CMD_TX_LAT) begin
      take_sample(DIR_TX, v);
    end else if (c == CMD_RX_LAT) begin
      take_sample(DIR_RX, v);
    end else if (c == CMD_CLEAR) begin
      clear_stats();
    end

    if (s < NUM_COUNTERS) return STAT_W'(evt_count[s]);
    if (s < STAT_RX_BASE) begin
      off = s - STAT_TX_BASE;
      return read_track(DIR_TX, off[2:0]);
    end
    if (s < STAT_END) begin
      off = s - STAT_RX_BASE;
      return read_track(DIR_RX, off[2:0]);
    end
    return '0;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic add_row(input logic [CMD_W-1:0] c, input logic [LAT_W-1:0] v,
                         input logic [SEL_W-1:0] s, input bit known,
                         input logic [STAT_W-1:0] value);
    stim_row_t r;
    r.cmd   = c;
    r.lat   = v;
    r.sel   = s;
    r.known = known;
    r.value = value;
    directed_rows.push_back(r);
  endtask

  // Offer one item; called at a falling edge, returns at a falling edge
  task automatic offer_event(input logic [CMD_W-1:0] c, input logic [LAT_W-1:0] v,
                             input logic [SEL_W-1:0] s, input bit known,
                             input logic [STAT_W-1:0] value);
    logic [STAT_W-1:0] predicted;
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= c;
    in_ch.latency_value <= v;
    in_ch.stat_index    <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    // accepted at this edge
    predicted = stat_after_event(c, v, s);
    expected_stats.push_back(known ? value : predicted);
    items_sent++;
    if (c == CMD_TX_LAT || c == CMD_RX_LAT) latency_items++;
    if (c == CMD_CLEAR) clear_items++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- result side

  // Receiver ready, with one long hold-off once results are flowing
  initial begin : result_ready
    int  hold_left;
    bit  held;
    hold_left    = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_checked >= HOLD_AT_ITEM) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_result
    logic [STAT_W-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $error("stat_value: unexpected item, actual %0d", out_ch.stat_value);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        if (out_ch.stat_value !== want) begin
          $error("stat_value: expected %0d, actual %0d", want, out_ch.stat_value);
          error_count++;
        end
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    logic [CMD_W-1:0] c;
    logic [LAT_W-1:0] v;
    logic [SEL_W-1:0] s;
    int               pick;

    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_NONE;
    in_ch.latency_value = '0;
    in_ch.stat_index    = '0;
    clear_stats();

    // Directed: reset values, each event, latency extremes, clear
    add_row(CMD_NONE, 16'd0, 5'd0, 1'b1, 48'd0);
    add_row(CMD_NONE, 16'd0, STAT_TX_BASE + SEL_W'(FLD_MIN), 1'b1, 48'd65535);
    add_row(CMD_NONE, 16'hFFFF, STAT_RX_BASE + SEL_W'(FLD_MIN), 1'b1, 48'd65535);
    add_row(CMD_NONE, 16'd0, SEL_TOP, 1'b1, 48'd0);
    add_row(CMD_SENT, 16'd0, CMD_SENT - 5'd1, 1'b1, 48'd1);
    add_row(CMD_PKT_RCVD, 16'd0, CMD_PKT_RCVD - 5'd1, 1'b1, 48'd1);
    add_row(CMD_ACK_SENT, 16'd0, CMD_ACK_SENT - 5'd1, 1'b1, 48'd1);
    add_row(CMD_ACK_RCVD, 16'd0, SEL_W'(CNT_IDX_RCVD), 1'b1, 48'd2);
    for (int e = CMD_ERR_FIRST; e < CMD_ERR_LAST; e++)
      add_row(CMD_W'(e), 16'd0, SEL_W'(e - 1), 1'b0, '0);
    add_row(CMD_ERR_LAST, 16'd0, SEL_W'(CNT_IDX_TOTAL), 1'b1, 48'd10);
    // zero latency is dropped
    add_row(CMD_TX_LAT, 16'd0, STAT_TX_BASE + SEL_W'(FLD_COUNT), 1'b1, 48'd0);
    add_row(CMD_TX_LAT, 16'hFFFF, STAT_TX_BASE + SEL_W'(FLD_MAX), 1'b1, 48'd65535);
    add_row(CMD_TX_LAT, 16'd1, STAT_TX_BASE + SEL_W'(FLD_MIN), 1'b1, 48'd1);
    add_row(CMD_TX_LAT, 16'd1, STAT_TX_BASE + SEL_W'(FLD_AVG), 1'b0, '0);
    add_row(CMD_RX_LAT, 16'hFFFF, STAT_RX_BASE + SEL_W'(FLD_AVG), 1'b1, 48'd65535);
    // unused code changes nothing
    add_row(CMD_UNUSED_TOP, 16'hFFFF, STAT_RX_BASE + SEL_W'(FLD_SUM), 1'b0, '0);
    add_row(CMD_CLEAR, 16'hFFFF, STAT_TX_BASE + SEL_W'(FLD_MIN), 1'b1, 48'd65535);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      offer_event(directed_rows[i].cmd, directed_rows[i].lat, directed_rows[i].sel,
                  directed_rows[i].known, directed_rows[i].value);

    // Random events
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= STEADY_FIRST && n < STEADY_LAST);
      pick = $urandom_range(99);
      if (pick < 2)       c = CMD_NONE;
      else if (pick < 6)  c = CMD_W'($urandom_range(CMD_UNUSED_LOW, CMD_UNUSED_TOP));
      else if (pick < 30) c = CMD_W'($urandom_range(CMD_SENT, CMD_ACK_RCVD));
      else if (pick < 55) c = CMD_W'($urandom_range(CMD_ERR_FIRST, CMD_ERR_LAST));
      else if (pick < 77) c = CMD_TX_LAT;
      else if (pick < 99) c = CMD_RX_LAT;
      else                c = CMD_CLEAR;

      pick = $urandom_range(9);
      case (pick)
        0:       v = '0;
        1:       v = 16'd1;
        2:       v = LAT_MAX;
        3, 4, 5: v = LAT_W'($urandom_range(1, 255));
        default: v = LAT_W'($urandom_range(0, 65535));
      endcase

      if ($urandom_range(9) == 0) s = SEL_W'($urandom_range(STAT_END, SEL_TOP));
      else                        s = SEL_W'($urandom_range(0, STAT_END - 1));

      offer_event(c, v, s, 1'b0, '0);
    end
    steady_flow = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain and let the pipeline settle
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d event items (%0d latency samples, %0d clears), checked %0d results,",
             items_sent, latency_items, clear_items, results_checked);
    $display("with random idling on both sides, a burst stretch and one long output stall.");
    if (error_count == 0) begin
      $display("link_statistics_counters_unit: match");
    end else begin
      $display("link_statistics_counters_unit: mismatch");
    end
    $finish;
  end

endmodule
